FILE: rtl/core/cmosrtc_pkg.sv
package cmosrtc_pkg;

	localparam int RamBytes = 128;
	localparam int AddrW    = $clog2(RamBytes);

	localparam logic OP_READ    = 1'b0;
	localparam logic OP_WRITE   = 1'b1;
	localparam logic PORT_INDEX = 1'b0;
	localparam logic PORT_DATA  = 1'b1;

	localparam logic [AddrW-1:0] ADDR_SEC     = 7'h00;
	localparam logic [AddrW-1:0] ADDR_MIN     = 7'h02;
	localparam logic [AddrW-1:0] ADDR_HOUR    = 7'h04;
	localparam logic [AddrW-1:0] ADDR_WDAY    = 7'h06;
	localparam logic [AddrW-1:0] ADDR_DAY     = 7'h07;
	localparam logic [AddrW-1:0] ADDR_MON     = 7'h08;
	localparam logic [AddrW-1:0] ADDR_YEAR    = 7'h09;
	localparam logic [AddrW-1:0] ADDR_STAT_A  = 7'h0a;
	localparam logic [AddrW-1:0] ADDR_STAT_B  = 7'h0b;
	localparam logic [AddrW-1:0] ADDR_STAT_D  = 7'h0d;
	localparam logic [AddrW-1:0] ADDR_BASE_LO = 7'h15;
	localparam logic [AddrW-1:0] ADDR_BASE_HI = 7'h16;
	localparam logic [AddrW-1:0] ADDR_EXT_LO  = 7'h17;
	localparam logic [AddrW-1:0] ADDR_EXT_HI  = 7'h18;
	localparam logic [AddrW-1:0] ADDR_EXT2_LO = 7'h30;
	localparam logic [AddrW-1:0] ADDR_EXT2_HI = 7'h31;
	localparam logic [AddrW-1:0] ADDR_CENT    = 7'h32;
	localparam logic [AddrW-1:0] ADDR_BOOT    = 7'h3d;

	localparam logic [7:0] STAT_A_INIT  = 8'h26;
	localparam logic [7:0] STAT_B_INIT  = 8'h02;
	localparam logic [7:0] STAT_D_INIT  = 8'h80;
	localparam logic [7:0] BASE_LO_INIT = 8'h80;
	localparam logic [7:0] BASE_HI_INIT = 8'h02;
	localparam logic [7:0] BOOT_INIT    = 8'h02;

	localparam logic [6:0] CENTURY_BASE = 7'd19;

	typedef struct packed {
		logic        op;
		logic        port;
		logic [7:0]  write_data;
		logic [5:0]  now_seconds;
		logic [5:0]  now_minutes;
		logic [4:0]  now_hours;
		logic [2:0]  now_weekday;
		logic [4:0]  now_day;
		logic [3:0]  now_month;
		logic [12:0] now_year;
	} cmosrtc_in_t;

	typedef struct packed {
		logic [7:0] read_data;
	} cmosrtc_out_t;

	// time fields with the year already split into year mod 100 and century
	typedef struct packed {
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hour;
		logic [2:0] wday;
		logic [4:0] day;
		logic [3:0] mon;
		logic [6:0] yr_lo;
		logic [6:0] cent;
	} cmosrtc_tm_t;

	// v / 10 as (v * 205) >> 11, exact for v below 1029
	function automatic logic [7:0] bcd8(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  q;
		logic [6:0]  r;
		prod = 15'(v) * 15'd205;
		q    = prod[14:11];
		r    = v - 7'(q) * 7'd10;
		return {q, r[3:0]};
	endfunction

	function automatic logic [7:0] init_byte(input logic [AddrW-1:0] a,
			input logic [15:0] kb);
		logic [7:0] b;
		unique case (a)
			ADDR_STAT_A:                b = STAT_A_INIT;
			ADDR_STAT_B:                b = STAT_B_INIT;
			ADDR_STAT_D:                b = STAT_D_INIT;
			ADDR_BASE_LO:               b = BASE_LO_INIT;
			ADDR_BASE_HI:               b = BASE_HI_INIT;
			ADDR_EXT_LO, ADDR_EXT2_LO:  b = kb[7:0];
			ADDR_EXT_HI, ADDR_EXT2_HI:  b = kb[15:8];
			ADDR_BOOT:                  b = BOOT_INIT;
			default:                    b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/core/cmosrtc_if.sv
interface cmosrtc_req_if import cmosrtc_pkg::*; ();
	logic        valid;
	logic        ready;
	cmosrtc_in_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface cmosrtc_rsp_if import cmosrtc_pkg::*; ();
	logic         valid;
	logic         ready;
	cmosrtc_out_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/cmosrtc_clock.sv
module cmosrtc_clock import cmosrtc_pkg::*; (
	input  cmosrtc_tm_t      tm,
	input  logic [AddrW-1:0] addr,
	output logic             hit,
	output logic [7:0]       value
);

	logic [6:0] bin;

	always_comb begin
		hit = 1'b1;
		bin = 7'd0;
		unique case (addr)
			ADDR_SEC:  bin = {1'b0, tm.sec};
			ADDR_MIN:  bin = {1'b0, tm.min};
			ADDR_HOUR: bin = {2'b0, tm.hour};
			ADDR_WDAY: bin = {4'b0, tm.wday} + 7'd1;
			ADDR_DAY:  bin = {2'b0, tm.day};
			ADDR_MON:  bin = {3'b0, tm.mon} + 7'd1;
			ADDR_YEAR: bin = tm.yr_lo;
			ADDR_CENT: bin = tm.cent;
			default:   hit = 1'b0;
		endcase
	end

	assign value = bcd8(bin);

endmodule

FILE: rtl/core/cmos_rtc_index_data_port_core.sv
// channel | dir | payload                                   | handshake
// req     | in  | op, port, write_data, now_* time fields   | valid/ready
// rsp     | out | read_data, one word per read access       | valid/ready
//
// An accepted word is registered in the input stage, then updates the index
// or RAM (write) or loads the result register (read): one word per cycle
// while no read stalls; a read word reaches rsp via the result register.
// Reset clears the index and the RAM valid bits; unwritten RAM bytes read as
// their power-on values at once, so no clearing pass is needed.
// A read held in the input stage behind an unconsumed result stalls req.
module cmos_rtc_index_data_port_core import cmosrtc_pkg::*; #(
	parameter int EXT_MEM_MB = 64
) (
	input logic          clk,
	input logic          arst_n,
	cmosrtc_req_if.sink   req,
	cmosrtc_rsp_if.source rsp
);

	localparam int         ExtKbRaw = (EXT_MEM_MB - 1) * 1024;
	localparam logic [15:0] EXT_KB  = (ExtKbRaw > 65535) ? 16'hffff : 16'(ExtKbRaw);

	logic                  valid_s1;
	logic                  op_s1;
	logic                  port_s1;
	logic [7:0]            wdata_s1;
	cmosrtc_tm_t           tm_s1;

	logic [AddrW-1:0]      idx_q;
	logic [RamBytes-1:0]   vld_q;
	logic [7:0]            mem [RamBytes];
	logic                  out_vld_q;
	logic [7:0]            read_data_q;

	logic                  req_fire;
	logic                  adv;
	logic                  rd_load;
	logic                  mem_we;
	logic                  clk_hit;
	logic [7:0]            clk_byte;

	logic [25:0]           yr_prod;
	logic [6:0]            yr_div;
	logic [12:0]           yr_rem;
	cmosrtc_tm_t           tm_in;

	// year / 100 as (year * 5243) >> 19, exact over the 13-bit range
	always_comb begin
		yr_prod = 26'(req.payload.now_year) * 26'd5243;
		yr_div  = yr_prod[25:19];
		yr_rem  = req.payload.now_year - 13'(yr_div) * 13'd100;
		tm_in.sec   = req.payload.now_seconds;
		tm_in.min   = req.payload.now_minutes;
		tm_in.hour  = req.payload.now_hours;
		tm_in.wday  = req.payload.now_weekday;
		tm_in.day   = req.payload.now_day;
		tm_in.mon   = req.payload.now_month;
		tm_in.yr_lo = yr_rem[6:0];
		tm_in.cent  = yr_div + CENTURY_BASE;
	end

	assign adv       = valid_s1 && (op_s1 == OP_WRITE || !out_vld_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign req_fire  = req.valid && req.ready;
	assign rd_load   = adv && op_s1 == OP_READ;
	assign mem_we    = adv && op_s1 == OP_WRITE && port_s1 == PORT_DATA;

	cmosrtc_clock u_clock (
		.tm    (tm_s1),
		.addr  (idx_q),
		.hit   (clk_hit),
		.value (clk_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_vld_q <= 1'b0;
			idx_q     <= '0;
			vld_q     <= '0;
		end else begin
			if (req_fire)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;

			if (rd_load)
				out_vld_q <= 1'b1;
			else if (rsp.ready)
				out_vld_q <= 1'b0;

			if (adv && op_s1 == OP_WRITE && port_s1 == PORT_INDEX)
				idx_q <= wdata_s1[AddrW-1:0];

			if (mem_we)
				vld_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_s1    <= req.payload.op;
			port_s1  <= req.payload.port;
			wdata_s1 <= req.payload.write_data;
			tm_s1    <= tm_in;
		end
	end

	// clock bytes are always rebuilt from the time fields when read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[idx_q] <= wdata_s1;
		if (rd_load) begin
			if (port_s1 == PORT_INDEX)
				read_data_q <= 8'(idx_q);
			else if (clk_hit)
				read_data_q <= clk_byte;
			else if (vld_q[idx_q])
				read_data_q <= mem[idx_q];
			else
				read_data_q <= init_byte(idx_q, EXT_KB);
		end
	end

	assign rsp.valid             = out_vld_q;
	assign rsp.payload.read_data = read_data_q;

	a_read_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		rd_load |=> out_vld_q)
		else $error("read left input stage without a result word");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && op_s1 == OP_READ && out_vld_q && !rsp.ready))
		else $error("req stalled without a blocked read");

	a_index_write: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && op_s1 == OP_WRITE && port_s1 == PORT_INDEX)
		|=> idx_q == $past(wdata_s1[AddrW-1:0]))
		else $error("index write lost");

	a_data_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> vld_q[$past(idx_q)])
		else $error("RAM entry not marked written");

endmodule

FILE: tb/cmosrtc_monitor.sv
`timescale 1ns / 100ps

module cmosrtc_monitor import cmosrtc_pkg::*; #(
	parameter int EXT_MEM_MB = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	cmosrtc_req_if  req,
	cmosrtc_rsp_if  rsp,
	output int      errors,
	output int      pending
);

	localparam int ExtKbRaw = (EXT_MEM_MB >= 1) ? (EXT_MEM_MB - 1) * 1024 : 0;
	localparam logic [15:0] ExtKb = (ExtKbRaw > 65535) ? 16'hffff : 16'(ExtKbRaw);

	logic [AddrW-1:0] index_q;
	logic [7:0]       cmos_ram [RamBytes];
	logic [7:0]       read_bytes [$];
	logic [7:0]       want;
	int               fails;

	function automatic logic [7:0] to_bcd(input int unsigned v);
		return 8'(((v / 10) << 4) | (v % 10));
	endfunction

	task automatic load_clock(input cmosrtc_in_t w);
		cmos_ram[ADDR_SEC]  = to_bcd(w.now_seconds);
		cmos_ram[ADDR_MIN]  = to_bcd(w.now_minutes);
		cmos_ram[ADDR_HOUR] = to_bcd(w.now_hours);
		cmos_ram[ADDR_WDAY] = to_bcd(int'(w.now_weekday) + 1);
		cmos_ram[ADDR_DAY]  = to_bcd(w.now_day);
		cmos_ram[ADDR_MON]  = to_bcd(int'(w.now_month) + 1);
		cmos_ram[ADDR_YEAR] = to_bcd(int'(w.now_year) % 100);
		cmos_ram[ADDR_CENT] = to_bcd((int'(w.now_year) + 1900) / 100);
	endtask

	task automatic predict_access(input cmosrtc_in_t w);
		if (w.op == OP_WRITE) begin
			if (w.port == PORT_DATA)
				cmos_ram[index_q] = w.write_data;
			else
				index_q = w.write_data[AddrW-1:0];
		end else if (w.port == PORT_INDEX) begin
			read_bytes.push_back(8'(index_q));
		end else begin
			if (index_q <= ADDR_YEAR || index_q == ADDR_CENT)
				load_clock(w);
			read_bytes.push_back(cmos_ram[index_q]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q = '0;
			for (int a = 0; a < RamBytes; a++)
				cmos_ram[a] = 8'h00;
			cmos_ram[ADDR_STAT_A]  = STAT_A_INIT;
			cmos_ram[ADDR_STAT_B]  = STAT_B_INIT;
			cmos_ram[ADDR_STAT_D]  = STAT_D_INIT;
			cmos_ram[ADDR_BASE_LO] = BASE_LO_INIT;
			cmos_ram[ADDR_BASE_HI] = BASE_HI_INIT;
			cmos_ram[ADDR_EXT_LO]  = ExtKb[7:0];
			cmos_ram[ADDR_EXT_HI]  = ExtKb[15:8];
			cmos_ram[ADDR_EXT2_LO] = ExtKb[7:0];
			cmos_ram[ADDR_EXT2_HI] = ExtKb[15:8];
			cmos_ram[ADDR_BOOT]    = BOOT_INIT;
			read_bytes.delete();
			fails = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (req.valid && req.ready)
				predict_access(req.payload);
			if (rsp.valid && rsp.ready) begin
				if (read_bytes.size() == 0) begin
					$error("read_data: unexpected word %h", rsp.payload.read_data);
					fails++;
				end else begin
					want = read_bytes.pop_front();
					if (rsp.payload.read_data !== want) begin
						$error("read_data: expected %h, got %h", want,
							rsp.payload.read_data);
						fails++;
					end
				end
			end
			errors <= fails;
			pending <= read_bytes.size();
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import cmosrtc_pkg::*;

	logic clk;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	bit   hold_rsp = 1'b0;
	int   mismatches;
	int   pending_reads;

	cmosrtc_req_if req_ch ();
	cmosrtc_rsp_if rsp_ch ();

	cmos_rtc_index_data_port_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	cmosrtc_monitor mon (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (mismatches),
		.pending (pending_reads)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic cmosrtc_in_t rand_word(input logic op, input logic port,
			input logic [7:0] data);
		cmosrtc_in_t w;
		w.op = op;
		w.port = port;
		w.write_data = data;
		if ($urandom_range(0, 4) == 0) begin
			w.now_seconds = 6'($urandom);
			w.now_minutes = 6'($urandom);
			w.now_hours   = 5'($urandom);
			w.now_weekday = 3'($urandom);
			w.now_day     = 5'($urandom);
			w.now_month   = 4'($urandom);
			w.now_year    = 13'($urandom);
		end else begin
			w.now_seconds = 6'($urandom_range(0, 60));
			w.now_minutes = 6'($urandom_range(0, 59));
			w.now_hours   = 5'($urandom_range(0, 23));
			w.now_weekday = 3'($urandom_range(0, 6));
			w.now_day     = 5'($urandom_range(1, 31));
			w.now_month   = 4'($urandom_range(0, 11));
			w.now_year    = 13'($urandom_range(0, 8099));
		end
		return w;
	endfunction

	// clock addresses get picked often so refreshes are frequent
	function automatic logic [AddrW-1:0] pick_index();
		int k;
		if ($urandom_range(0, 9) < 3) begin
			k = $urandom_range(0, 10);
			return (k == 10) ? ADDR_CENT : AddrW'(k);
		end
		return AddrW'($urandom_range(0, RamBytes - 1));
	endfunction

	function automatic cmosrtc_in_t set_time(input cmosrtc_in_t w, input logic [5:0] s,
			input logic [5:0] m, input logic [4:0] h, input logic [2:0] wd,
			input logic [4:0] d, input logic [3:0] mo, input logic [12:0] y);
		w.now_seconds = s;
		w.now_minutes = m;
		w.now_hours   = h;
		w.now_weekday = wd;
		w.now_day     = d;
		w.now_month   = mo;
		w.now_year    = y;
		return w;
	endfunction

	task automatic send_word(input cmosrtc_in_t w);
		req_ch.valid <= 1'b1;
		req_ch.payload <= w;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (!calm && $urandom_range(0, 99) < 7) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (80) @(posedge clk);
			end else begin
				rsp_ch.ready <= calm || $urandom_range(0, 99) >= 7;
			end
		end
	end

	initial begin
		cmosrtc_in_t w;
		int k;
		req_ch.valid <= 1'b0;
		req_ch.payload <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(rand_word(OP_READ, PORT_INDEX, 8'hff));
		send_word(set_time(rand_word(OP_READ, PORT_DATA, 8'h00), 0, 0, 0, 0, 0, 0, 0));
		send_word(rand_word(OP_WRITE, PORT_INDEX, {1'b1, ADDR_STAT_A}));
		send_word(rand_word(OP_READ, PORT_INDEX, 8'h00));
		send_word(rand_word(OP_READ, PORT_DATA, 8'h00));
		send_word(rand_word(OP_WRITE, PORT_INDEX, {1'b0, ADDR_EXT_HI}));
		send_word(rand_word(OP_READ, PORT_DATA, 8'h00));
		send_word(rand_word(OP_WRITE, PORT_INDEX, {1'b0, ADDR_CENT}));
		w = set_time(rand_word(OP_READ, PORT_DATA, 8'hff), '1, '1, '1, '1, '1, '1, '1);
		send_word(w);
		send_word(rand_word(OP_WRITE, PORT_DATA, 8'h55));
		send_word(set_time(rand_word(OP_READ, PORT_DATA, 8'h00), 0, 0, 0, 0, 1, 0, 0));
		send_word(rand_word(OP_WRITE, PORT_INDEX, {1'b1, ADDR_YEAR}));
		send_word(set_time(rand_word(OP_READ, PORT_DATA, 8'h00), 60, 59, 23, 6, 31, 11,
			8099));
		send_word(rand_word(OP_WRITE, PORT_INDEX, 8'h7f));
		send_word(rand_word(OP_WRITE, PORT_DATA, 8'hff));
		send_word(rand_word(OP_READ, PORT_DATA, 8'h00));
		send_word(rand_word(OP_READ, PORT_INDEX, 8'h00));
		send_word(rand_word(OP_WRITE, PORT_INDEX, 8'h01));
		send_word(rand_word(OP_WRITE, PORT_DATA, 8'ha5));
		send_word(rand_word(OP_READ, PORT_DATA, 8'h00));
		send_word(rand_word(OP_WRITE, PORT_INDEX, {1'b0, ADDR_BOOT}));
		send_word(rand_word(OP_READ, PORT_DATA, 8'h00));
		send_word(rand_word(OP_WRITE, PORT_DATA, 8'h00));
		send_word(rand_word(OP_READ, PORT_DATA, 8'h00));

		// first stretch has no data writes so power-on bytes get seen
		for (int n = 0; n < 1526; n++) begin
			if (n == 500)
				hold_rsp = 1'b1;
			if (n == 700) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending_reads != 0)
					@(posedge clk);
			end
			calm = (n >= 900 && n < 1200);
			k = $urandom_range(0, 99);
			if (k < 30)
				w = rand_word(OP_WRITE, PORT_INDEX, {1'($urandom), pick_index()});
			else if (k < 45)
				w = rand_word(OP_READ, PORT_INDEX, 8'($urandom));
			else if (k < 70 || n < 400)
				w = rand_word(OP_READ, PORT_DATA, 8'($urandom));
			else
				w = rand_word(OP_WRITE, PORT_DATA, 8'($urandom));
			send_word(w);
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_reads != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: cmos_rtc_index_data_port_core.f
rtl/core/cmosrtc_pkg.sv
rtl/core/cmosrtc_if.sv
rtl/core/cmosrtc_clock.sv
rtl/core/cmos_rtc_index_data_port_core.sv
tb/cmosrtc_monitor.sv
tb/tb.sv
